@@ hdl/mrffd_pkg.sv @@
// ----------------------------------------------------------------------------
// mrffd_pkg
// Types and constants for the receive frame filter with duplicate detection.
// ----------------------------------------------------------------------------
package mrffd_pkg;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned SEQ_W   = 16;
  localparam int unsigned HSEQ_W  = 8;
  localparam int unsigned CIDX_W  = 2;

  localparam logic [SEQ_W-1:0] NO_SEQUENCE = 16'hFFFF;

  typedef enum logic [1:0] {
    VERDICT_ACCEPTED    = 2'd0,
    VERDICT_PARSE_ERROR = 2'd1,
    VERDICT_NOT_FOR_US  = 2'd2,
    VERDICT_DUPLICATE   = 2'd3
  } verdict_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_NODE_ADDRESS    = 2'd0,
    REG_ADDR_FILTER_ON  = 2'd1,
    REG_DUP_CHECK_ON    = 2'd2,
    REG_UNUSED          = 2'd3
  } cfg_reg_t;

endpackage

@@ hdl/mac_rx_frame_filter_dedup.sv @@
// ----------------------------------------------------------------------------
// mac_rx_frame_filter_dedup
// Receive-side frame filter: parse check, receiver address filter and
// duplicate detection against a shift history of (sender, sequence) pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one received frame header per transfer, taken when
//   in_valid is high and in_stall is low.
//   Result channel (out_*): one 2-bit verdict per frame, in order.
//   Config channel (cfg_*): register writes, cfg_ready is always high.
//   Write only while no frame is in flight.
// The verdict is registered on the input transfer, valid in the cycle after.
// Throughput: one frame per cycle while in_stall is low. The history compare
//   and the shift update both happen in the cycle of the input transfer, so
//   the next frame sees the updated history at once.
// Reset (rst_n low, synchronous): result register empty, history cleared to
//   sender 0 / sequence 0, node address 0, both filter flags on.
// Receiver stall: the verdict register holds; in_stall is raised only while
//   a verdict is held and out_stall is high, so a new frame is taken in the
//   same cycle that the held verdict leaves.
// ----------------------------------------------------------------------------
module mac_rx_frame_filter_dedup
  import mrffd_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_parse_ok,
  input  logic [ADDR_W-1:0]   in_receiver_address,
  input  logic [ADDR_W-1:0]   in_sender_address,
  input  logic [SEQ_W-1:0]    in_sequence_req,

  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_verdict,

  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [ADDR_W-1:0]   cfg_data
);

  logic [ADDR_W-1:0] node_address_r;
  logic              addr_filter_on_r;
  logic              dup_check_on_r;

  logic [ADDR_W-1:0] hist_sender_r [HISTORY_DEPTH];
  logic [HSEQ_W-1:0] hist_seq_r    [HISTORY_DEPTH];

  logic              out_valid_r, out_valid_nxt;
  verdict_t          out_verdict_r, verdict_nxt;

  logic              in_xfer;
  logic              not_for_us;
  logic              seq_valid;
  logic              hist_hit;
  logic              push;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_xfer   = in_valid & ~in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_address_r   <= '0;
      addr_filter_on_r <= 1'b1;
      dup_check_on_r   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_NODE_ADDRESS:   node_address_r   <= cfg_data;
        REG_ADDR_FILTER_ON: addr_filter_on_r <= cfg_data[0];
        REG_DUP_CHECK_ON:   dup_check_on_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // verdict logic
  always_comb begin
    not_for_us = addr_filter_on_r &&
                 (in_receiver_address != node_address_r) &&
                 (in_receiver_address != '0);
    seq_valid  = dup_check_on_r && (in_sequence_req != NO_SEQUENCE);

    // stored byte is compared zero-extended against the full attribute
    hist_hit = 1'b0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if ((in_sequence_req[SEQ_W-1:HSEQ_W] == '0) &&
          (in_sequence_req[HSEQ_W-1:0] == hist_seq_r[i]) &&
          (in_sender_address == hist_sender_r[i]))
        hist_hit = 1'b1;
    end

    push = 1'b0;
    if (!in_parse_ok) begin
      verdict_nxt = VERDICT_PARSE_ERROR;
    end else if (not_for_us) begin
      verdict_nxt = VERDICT_NOT_FOR_US;
    end else if (seq_valid && hist_hit) begin
      verdict_nxt = VERDICT_DUPLICATE;
    end else begin
      verdict_nxt = VERDICT_ACCEPTED;
      push        = seq_valid;
    end

    out_valid_nxt = out_valid_r;
    if (in_xfer)
      out_valid_nxt = 1'b1;
    else if (!out_stall)
      out_valid_nxt = 1'b0;
  end

  // shift history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_sender_r[i] <= '0;
        hist_seq_r[i]    <= '0;
      end
    end else if (in_xfer && push) begin
      for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
        hist_sender_r[i] <= hist_sender_r[i-1];
        hist_seq_r[i]    <= hist_seq_r[i-1];
      end
      hist_sender_r[0] <= in_sender_address;
      hist_seq_r[0]    <= in_sequence_req[HSEQ_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else
      out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_xfer)
      out_verdict_r <= verdict_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

`ifndef SYNTHESIS
  a_parse_err: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_parse_ok) |=> (out_verdict_r == VERDICT_PARSE_ERROR))
    else $error("parse failure did not yield parse error verdict");

  a_dup_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && verdict_nxt == VERDICT_DUPLICATE) |=>
      ($stable(hist_sender_r[0]) && $stable(hist_seq_r[0])))
    else $error("history changed on duplicate frame");

  a_push_head: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && push) |=> (hist_sender_r[0] == $past(in_sender_address)))
    else $error("pushed sender not at history head");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !in_xfer)
    else $error("input transfer while verdict held");
`endif

endmodule

@@ verif/mac_rx_frame_filter_dedup_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mac_rx_frame_filter_dedup_tb
// Self-checking bench for the receive frame filter. Frame headers are pushed
// through the input channel under random sender gaps and receiver stalls. A
// local predictor keeps its own address filter settings and (sender, sequence)
// history and works out the verdict for every header taken. Each returned
// verdict is checked in order against that prediction.
// ----------------------------------------------------------------------------
module mac_rx_frame_filter_dedup_tb
  import mrffd_pkg::*;
;

  localparam int unsigned HIST_DEPTH = 8;
  localparam int unsigned N_PHASES   = 10;
  localparam int unsigned PHASE_LEN  = 115;

  typedef struct {
    logic              parse_ok;
    logic [ADDR_W-1:0] rx_addr;
    logic [ADDR_W-1:0] tx_addr;
    logic [SEQ_W-1:0]  seq;
  } frame_hdr_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_parse_ok = 1'b0;
  logic [ADDR_W-1:0] in_receiver_address = '0;
  logic [ADDR_W-1:0] in_sender_address = '0;
  logic [SEQ_W-1:0]  in_sequence_req = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_verdict;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0] cfg_data = '0;

  // predictor state
  logic [ADDR_W-1:0] node_addr_q = '0;
  logic              filter_on_q = 1'b1;
  logic              dedup_on_q = 1'b1;
  logic [ADDR_W-1:0] seen_sender [HIST_DEPTH];
  logic [HSEQ_W-1:0] seen_seq [HIST_DEPTH];

  frame_hdr_t frame_q[$];
  verdict_t   verdict_q[$];
  frame_hdr_t drv_hdr;
  int unsigned frames_queued = 0;
  int unsigned frames_taken = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 21;
  int unsigned recv_idle_pct = 59;

  mac_rx_frame_filter_dedup #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_parse_ok        (in_parse_ok),
    .in_receiver_address(in_receiver_address),
    .in_sender_address  (in_sender_address),
    .in_sequence_req    (in_sequence_req),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_verdict        (out_verdict),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < HIST_DEPTH; i++) begin
      seen_sender[i] = '0;
      seen_seq[i] = '0;
    end
  end

  // Verdict for one header; updates the history like the block does.
  function automatic verdict_t judge_frame(frame_hdr_t f);
    logic hit;
    hit = 1'b0;
    if (!f.parse_ok) return VERDICT_PARSE_ERROR;
    if (filter_on_q && f.rx_addr != node_addr_q && f.rx_addr != '0)
      return VERDICT_NOT_FOR_US;
    if (!dedup_on_q || f.seq == NO_SEQUENCE) return VERDICT_ACCEPTED;
    // stored byte is zero-extended, so a wide sequence never matches
    for (int i = 0; i < HIST_DEPTH; i++)
      if (f.seq == {8'h00, seen_seq[i]} && f.tx_addr == seen_sender[i]) hit = 1'b1;
    if (hit) return VERDICT_DUPLICATE;
    for (int i = HIST_DEPTH - 1; i > 0; i--) begin
      seen_sender[i] = seen_sender[i-1];
      seen_seq[i] = seen_seq[i-1];
    end
    seen_sender[0] = f.tx_addr;
    seen_seq[0] = f.seq[HSEQ_W-1:0];
    return VERDICT_ACCEPTED;
  endfunction

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  task automatic queue_frame(input logic ok, input logic [ADDR_W-1:0] rx,
                             input logic [ADDR_W-1:0] tx, input logic [SEQ_W-1:0] seq);
    frame_hdr_t h;
    h.parse_ok = ok;
    h.rx_addr = rx;
    h.tx_addr = tx;
    h.seq = seq;
    frame_q.push_back(h);
    frames_queued++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [ADDR_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_NODE_ADDRESS:   node_addr_q = value;
      REG_ADDR_FILTER_ON: filter_on_q = value[0];
      REG_DUP_CHECK_ON:   dedup_on_q = value[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (frames_taken != frames_queued || verdict_q.size() != 0) @(posedge clk);
  endtask

  // driver: payload holds while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (frame_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_hdr = frame_q.pop_front();
        in_valid <= 1'b1;
        in_parse_ok <= drv_hdr.parse_ok;
        in_receiver_address <= drv_hdr.rx_addr;
        in_sender_address <= drv_hdr.tx_addr;
        in_sequence_req <= drv_hdr.seq;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // monitor: check the verdict transfer, then predict the header transfer
  always @(posedge clk) begin
    frame_hdr_t h;
    verdict_t   exp_v;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          log_mismatch($sformatf("verdict %0d with none expected", out_verdict));
        end else begin
          exp_v = verdict_q.pop_front();
          if (out_verdict !== exp_v)
            log_mismatch($sformatf("verdict: expected %s (%0d), got %0d",
                                   exp_v.name(), exp_v, out_verdict));
        end
      end
      if (in_valid && !in_stall) begin
        h.parse_ok = in_parse_ok;
        h.rx_addr = in_receiver_address;
        h.tx_addr = in_sender_address;
        h.seq = in_sequence_req;
        verdict_q.push_back(judge_frame(h));
        frames_taken++;
      end
    end
  end

  initial begin
    logic [ADDR_W-1:0] node;
    logic [ADDR_W-1:0] val;
    logic [ADDR_W-1:0] rx;
    logic [ADDR_W-1:0] tx;
    logic [SEQ_W-1:0]  seq;
    logic [ADDR_W-1:0] sender_pool [4];
    int unsigned       pick;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: node 0, filter on, checking on, history all zero
    queue_frame(1'b0, '1, '1, '1);                // parse error first
    queue_frame(1'b1, '0, '0, 16'h0000);          // matches the zeroed history
    queue_frame(1'b1, '0, '0, NO_SEQUENCE);       // no sequence, accepted
    queue_frame(1'b1, '1, '0, 16'h0001);          // not for node 0
    queue_frame(1'b1, '0, '1, 16'h00FF);
    queue_frame(1'b1, '0, '1, 16'h00FF);          // duplicate
    queue_frame(1'b1, '0, '1, 16'hFFFE);          // stores 0xFE
    queue_frame(1'b1, '0, '1, 16'h00FE);          // hits the truncated byte
    queue_frame(1'b1, '0, '1, 16'hFFFE);          // wide sequence never matches
    queue_frame(1'b1, '0, '0, 16'h0100);
    queue_frame(1'b0, '0, '1, 16'h00FF);          // rejected, history untouched
    wait_drained();

    node = {$urandom, $urandom} | 64'h1;
    write_reg(REG_NODE_ADDRESS, node);
    queue_frame(1'b1, node, 64'h5, 16'h0005);
    queue_frame(1'b1, node ^ 64'h8000_0000_0000_0000, 64'h5, 16'h0006);
    queue_frame(1'b1, '0, 64'h5, 16'h0005);       // broadcast, duplicate
    wait_drained();

    write_reg(REG_ADDR_FILTER_ON, 64'hFFFF_FFFF_FFFF_FFFE);  // only bit 0 counts
    queue_frame(1'b1, ~node, 64'h7, 16'h0007);
    wait_drained();

    write_reg(REG_DUP_CHECK_ON, 64'hFFFF_FFFF_FFFF_FFFE);
    write_reg(REG_UNUSED, '1);                    // must be ignored
    queue_frame(1'b1, '0, '0, 16'h0000);
    queue_frame(1'b1, '0, 64'h9, 16'h0009);
    queue_frame(1'b1, '0, 64'h9, 16'h0009);       // not stored, accepted again
    wait_drained();

    for (int p = 0; p < N_PHASES; p++) begin
      if (p < 3) begin
        send_idle_pct = 21;
        recv_idle_pct = 59;
      end else if (p < 6) begin
        send_idle_pct = 59;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      node = (p == 0) ? '0 : (p == 1) ? '1 : {$urandom, $urandom};
      write_reg(REG_NODE_ADDRESS, node);
      val = {$urandom, $urandom};
      val[0] = (p % 3) != 2;
      write_reg(REG_ADDR_FILTER_ON, val);
      val = {$urandom, $urandom};
      val[0] = (p % 4) != 3;
      write_reg(REG_DUP_CHECK_ON, val);
      write_reg(REG_UNUSED, {$urandom, $urandom});

      sender_pool[0] = '0;
      sender_pool[1] = '1;
      sender_pool[2] = {$urandom, $urandom};
      sender_pool[3] = {$urandom, $urandom};

      for (int k = 0; k < PHASE_LEN; k++) begin
        pick = $urandom_range(99);
        rx = (pick < 45) ? node : (pick < 70) ? '0 : {$urandom, $urandom};
        tx = ($urandom_range(99) < 80) ? sender_pool[$urandom_range(3)]
                                       : {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 40)      seq = SEQ_W'($urandom_range(7));
        else if (pick < 55) seq = NO_SEQUENCE;
        else if (pick < 70) seq = SEQ_W'($urandom_range(255));
        else if (pick < 85) seq = SEQ_W'($urandom);
        else                seq = {8'($urandom_range(1, 255)), 8'($urandom_range(7))};
        queue_frame($urandom_range(99) < 92, rx, tx, seq);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
